/* rtl/core/ultrasonic_echo_ranging_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ultrasonic echo ranging block
// Implication checks on the rising clock edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGING_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGING_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define UER_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define UER_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define UER_ASSERT_IMP(lbl, ante, cons)
`define UER_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/uer_pkg.sv */
// ----------------------------------------------------------------------------
// Ultrasonic echo ranging package
// Status codes, register indexes, field widths and shared types.
// ----------------------------------------------------------------------------
package uer_pkg;

    // Field widths fixed by the register map and the item layout.
    localparam int TW_BITS       = 16;
    localparam int TO_BITS       = 24;
    localparam int DIST_BITS     = 24;
    localparam int SPEED_BITS    = 12;
    localparam int SPEED_SHIFT   = 13;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 32;

    // Measurement status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_STUCK   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_DIST    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DIST    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SOUND_SPEED = 3'd4;

    // Register values after reset.
    localparam logic [TW_BITS-1:0]    RST_TRIG_WIDTH  = 16'd10;
    localparam logic [TO_BITS-1:0]    RST_TIMEOUT     = 24'd30000;
    localparam logic [DIST_BITS-1:0]  RST_MIN_DIST    = 24'd32;
    localparam logic [DIST_BITS-1:0]  RST_MAX_DIST    = 24'd6400;
    localparam logic [SPEED_BITS-1:0] RST_SOUND_SPEED = 12'd2248;

    // Per-tick result of the sequencer; chk marks a finished echo whose
    // distance still has to be range checked.
    typedef struct packed {
        logic       trig;
        logic       busy;
        logic       done;
        logic [1:0] status;
        logic       chk;
    } t_seq_res;

endpackage

/* rtl/core/ultrasonic_echo_ranging.sv */
// ----------------------------------------------------------------------------
// Ultrasonic echo ranging
// A result passes the input register, the sequencer and product register
// and the result register, in that order, before it is valid on the
// output. Throughput: one transaction per cycle while the output is taken,
// set by the three-stage pipeline; the stages behind the output register
// keep taking input while a result waits, until they are full.
// Reset: synchronous, active low; clears the pipeline, the sequencer phase
// and counter, and loads the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranging #(
    parameter int COUNT_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream: one transaction per microsecond tick.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] start_req, [1] echo_level, [7:2] zero
    input  logic [uer_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
    // Result stream: one transaction per input tick.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] trig_out, [1] busy_res, [2] done_res, [4:3] status,
    // [28:5] distance, [31:29] zero
    output logic [uer_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [uer_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [uer_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import uer_pkg::*;

    `include "ultrasonic_echo_ranging_assert.svh"

    // Product of the high-time count and the Q0.13 speed of sound.
    localparam int PW  = COUNT_BITS + SPEED_BITS;
    // Wide enough to hold the shifted product and a saturation flag above.
    localparam int EXT = PW + DIST_BITS;

    // Configuration registers.
    logic [TW_BITS-1:0]    r_trig_width;
    logic [TO_BITS-1:0]    r_timeout;
    logic [DIST_BITS-1:0]  r_min_dist;
    logic [DIST_BITS-1:0]  r_max_dist;
    logic [SPEED_BITS-1:0] r_speed;

    // Stage A: registered input transaction.
    logic r_a_vld, r_a_start, r_a_echo;
    // Stage B: sequencer result and distance product.
    logic              r_b_vld;
    t_seq_res          r_b_res;
    logic [PW-1:0]     r_b_prod;
    // Stage C: output register.
    logic                 r_c_vld;
    logic                 r_c_trig, r_c_busy, r_c_done;
    logic [1:0]           r_c_status;
    logic [DIST_BITS-1:0] r_c_dist;

    logic w_s_acc, w_take_b, w_take_c, w_b_free;
    t_seq_res              w_seq_res;
    logic [COUNT_BITS-1:0] w_count;
    logic [PW-1:0]         w_prod;
    logic [EXT-1:0]        w_shifted;
    logic [DIST_BITS-1:0]  w_dist;
    logic                  w_bad_range;
    logic [1:0]            n_status;
    logic [DIST_BITS-1:0]  n_dist;

    // ------------------------------------------------------------------------
    // Configuration. Writes are taken in any cycle; the user must change the
    // register map only while no measurement tick is in flight (not enforced
    // by the block); no shadowing is kept. Unlisted indexes are taken as no-ops.
    // ------------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_width <= RST_TRIG_WIDTH;
            r_timeout    <= RST_TIMEOUT;
            r_min_dist   <= RST_MIN_DIST;
            r_max_dist   <= RST_MAX_DIST;
            r_speed      <= RST_SOUND_SPEED;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TRIG_WIDTH:  r_trig_width <= i_cfg_data[TW_BITS-1:0];
                CFG_TIMEOUT:     r_timeout    <= i_cfg_data[TO_BITS-1:0];
                CFG_MIN_DIST:    r_min_dist   <= i_cfg_data[DIST_BITS-1:0];
                CFG_MAX_DIST:    r_max_dist   <= i_cfg_data[DIST_BITS-1:0];
                CFG_SOUND_SPEED: r_speed      <= i_cfg_data[SPEED_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline flow control. Each stage holds its transaction until the next
    // stage has room, so a stalled output only backs up the stages behind it.
    // ------------------------------------------------------------------------
    assign w_take_c      = r_b_vld && (!r_c_vld || m_axis_tready);
    assign w_b_free      = !r_b_vld || w_take_c;
    assign w_take_b      = r_a_vld && w_b_free;
    assign s_axis_tready = !r_a_vld || w_take_b;
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            if (w_s_acc) begin
                r_a_vld <= 1'b1;
            end else if (w_take_b) begin
                r_a_vld <= 1'b0;
            end
            if (w_take_b) begin
                r_b_vld <= 1'b1;
            end else if (w_take_c) begin
                r_b_vld <= 1'b0;
            end
            if (w_take_c) begin
                r_c_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_c_vld <= 1'b0;
            end
        end
    end

    // Stage A: capture the tick sample.
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_a_start <= s_axis_tdata[0];
            r_a_echo  <= s_axis_tdata[1];
        end
    end

    // ------------------------------------------------------------------------
    // Stage B: the sequencer advances once per tick as the transaction moves
    // on, and the count it ends on is multiplied by the speed of sound. The
    // product is only used when the sequencer flags a finished echo.
    // ------------------------------------------------------------------------
    uer_seq #(
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_take_b),
        .i_start      (r_a_start),
        .i_echo       (r_a_echo),
        .i_trig_width (r_trig_width),
        .i_timeout    (r_timeout),
        .o_res        (w_seq_res),
        .o_count      (w_count)
    );

    assign w_prod = PW'(w_count) * PW'(r_speed);

    always_ff @(posedge i_clk) begin
        if (w_take_b) begin
            r_b_res  <= w_seq_res;
            r_b_prod <= w_prod;
        end
    end

    // ------------------------------------------------------------------------
    // Stage C: scale the product to 1/16 cm, saturate to the field width and
    // check the accepted range. A reversed range rejects every measurement.
    // ------------------------------------------------------------------------
    assign w_shifted   = EXT'(r_b_prod) >> SPEED_SHIFT;
    assign w_dist      = (|w_shifted[EXT-1:DIST_BITS]) ? '1 : w_shifted[DIST_BITS-1:0];
    assign w_bad_range = (w_dist < r_min_dist) || (w_dist > r_max_dist);

    always_comb begin
        n_status = r_b_res.status;
        n_dist   = '0;
        if (r_b_res.chk) begin
            if (w_bad_range) begin
                n_status = ST_RANGE;
            end else begin
                n_status = ST_OK;
                n_dist   = w_dist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_c) begin
            r_c_trig   <= r_b_res.trig;
            r_c_busy   <= r_b_res.busy;
            r_c_done   <= r_b_res.done;
            r_c_status <= n_status;
            r_c_dist   <= n_dist;
        end
    end

    assign m_axis_tvalid = r_c_vld;
    assign m_axis_tdata  = {3'b000, r_c_dist, r_c_status, r_c_done, r_c_busy, r_c_trig};

    // A finished measurement never drives the trigger or reports busy.
    `UER_ASSERT_IMP(a_done_not_busy, r_c_vld && r_c_done, !r_c_busy && !r_c_trig)
    // A status other than ok is only reported on the finishing tick.
    `UER_ASSERT_IMP(a_status_on_done, r_c_vld && (r_c_status != ST_OK), r_c_done)
    // A distance is only reported with a good finished measurement.
    `UER_ASSERT_IMP(a_dist_on_ok, r_c_vld && (r_c_dist != '0), r_c_done && (r_c_status == ST_OK))
    // The trigger is driven only as part of a running measurement.
    `UER_ASSERT_IMP(a_trig_busy, r_c_vld && r_c_trig, r_c_busy)
    // A tick leaving the input register always lands in the product stage.
    `UER_ASSERT_NXT(a_stage_b_fill, w_take_b, r_b_vld)

endmodule

/* rtl/core/uer_seq.sv */
// ----------------------------------------------------------------------------
// Ultrasonic echo ranging sequencer
// Trigger, rise wait and echo-high phases with the tick counter.
// ----------------------------------------------------------------------------
module uer_seq #(
    parameter int COUNT_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_start,
    input  logic                          i_echo,
    input  logic [uer_pkg::TW_BITS-1:0]   i_trig_width,
    input  logic [uer_pkg::TO_BITS-1:0]   i_timeout,
    output uer_pkg::t_seq_res             o_res,
    output logic [COUNT_BITS-1:0]         o_count
);
    import uer_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_RISE = 2'd2;
    localparam logic [1:0] PH_HIGH = 2'd3;

    localparam int XW = (COUNT_BITS > TO_BITS) ? COUNT_BITS : TO_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [1:0]            r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [COUNT_BITS-1:0] w_base, w_inc;
    logic                  w_trig_end, w_to_cur, w_to_inc;
    t_seq_res              w_res;

    // The idle start tick behaves as a trigger tick counted from zero.
    assign w_base = (r_phase == PH_IDLE) ? '0 : r_count;
    assign w_inc  = (w_base == CNT_MAX) ? CNT_MAX : w_base + COUNT_BITS'(1);

    assign w_trig_end = (w_inc >= COUNT_BITS'(i_trig_width)) || (w_inc == CNT_MAX);
    assign w_to_cur   = (XW'(r_count) > XW'(i_timeout)) || (r_count == CNT_MAX);
    assign w_to_inc   = (XW'(w_inc) > XW'(i_timeout)) || (w_inc == CNT_MAX);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        w_res   = '0;
        case (r_phase)
            PH_TRIG: begin
                w_res.trig = 1'b1;
                w_res.busy = 1'b1;
                if (w_trig_end) begin
                    n_phase = PH_RISE;
                    n_count = '0;
                end else begin
                    n_count = w_inc;
                end
            end
            PH_RISE: begin
                if (i_echo) begin
                    w_res.busy = 1'b1;
                    n_phase    = PH_HIGH;
                    n_count    = '0;
                end else if (w_to_cur) begin
                    w_res.done   = 1'b1;
                    w_res.status = ST_TIMEOUT;
                    n_phase      = PH_IDLE;
                    n_count      = '0;
                end else begin
                    w_res.busy = 1'b1;
                    n_count    = w_inc;
                end
            end
            PH_HIGH: begin
                if (!i_echo) begin
                    w_res.done = 1'b1;
                    w_res.chk  = 1'b1;
                    n_phase    = PH_IDLE;
                    n_count    = '0;
                end else if (w_to_inc) begin
                    w_res.done   = 1'b1;
                    w_res.status = ST_TIMEOUT;
                    n_phase      = PH_IDLE;
                    n_count      = '0;
                end else begin
                    w_res.busy = 1'b1;
                    n_count    = w_inc;
                end
            end
            default: begin
                if (i_start && i_echo) begin
                    w_res.done   = 1'b1;
                    w_res.status = ST_STUCK;
                end else if (i_start) begin
                    w_res.trig = 1'b1;
                    w_res.busy = 1'b1;
                    if (w_trig_end) begin
                        n_phase = PH_RISE;
                        n_count = '0;
                    end else begin
                        n_phase = PH_TRIG;
                        n_count = w_inc;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    assign o_res   = w_res;
    assign o_count = w_inc;

endmodule
